/* sv/euler_to_quaternion_defines.svh */
// Assertion macros shared by the checker of the Euler angle to quaternion block.
// Depends on nothing; the user supplies clock and reset names in scope.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define E2Q_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/eul2q_pkg.sv */
// Shared types and constants of the Euler angle to quaternion block.
// Used by the CORDIC lanes, the merge stage and the top level; depends on nothing.
package eul2q_pkg;

   localparam int CORDIC_ITERS = 24;
   // CORDIC datapath width: Q.30 values with headroom for the gain and the residual angle.
   localparam int ZW = 33;
   localparam int LANE_LAT = CORDIC_ITERS + 2;
   localparam int MERGE_LAT = 4;
   localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

   localparam logic signed [ZW-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
   localparam logic signed [ZW:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ZW-1:0] ROUND_Q16 = 33'sd32768;
   localparam int ONE_Q14 = 16384;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
      33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
      33'sd67021686, 33'sd33543515, 33'sd16775850, 33'sd8388437,
      33'sd4194282, 33'sd2097149, 33'sd1048575, 33'sd524287,
      33'sd262143, 33'sd131071, 33'sd65535, 33'sd32767,
      33'sd16383, 33'sd8191, 33'sd4095, 33'sd2047,
      33'sd1023, 33'sd511, 33'sd255, 33'sd127
   };

   typedef logic signed [15:0] angle_type;
   typedef logic signed [15:0] q14_type;
   typedef logic signed [ZW-1:0] cordic_type;

endpackage

/* sv/eul2q_cordic_lane.sv */
// One lane: sine and cosine of half a Q4.12 angle through a pipelined CORDIC.
// Depends on eul2q_pkg. Its registers advance only while en is high.
module eul2q_cordic_lane (
   input  logic                clock,
   input  logic                en,
   input  eul2q_pkg::angle_type angle,
   output eul2q_pkg::q14_type  sin_q14,
   output eul2q_pkg::q14_type  cos_q14
);

   localparam int ITERS = eul2q_pkg::CORDIC_ITERS;
   localparam int ZW = eul2q_pkg::ZW;

   eul2q_pkg::cordic_type x_ff [0:ITERS];
   eul2q_pkg::cordic_type y_ff [0:ITERS];
   eul2q_pkg::cordic_type z_ff [0:ITERS-1];
   logic                  neg_ff [0:ITERS];

   eul2q_pkg::cordic_type z_half;
   logic signed [ZW:0]    z_wide;
   eul2q_pkg::cordic_type z_red_in;
   logic                  neg_in;

   // The half angle in units of 2^-30 rad is the raw value shifted left by 17.
   always_comb begin
      z_half = $signed({angle, 17'b0});
      z_wide = {z_half[ZW-1], z_half};
      neg_in = 1'b0;
      if (z_half > eul2q_pkg::HALF_PI_Q30) begin
         z_wide = z_wide - eul2q_pkg::PI_Q30;
         neg_in = 1'b1;
      end else if (z_half < -eul2q_pkg::HALF_PI_Q30) begin
         z_wide = z_wide + eul2q_pkg::PI_Q30;
         neg_in = 1'b1;
      end
      z_red_in = z_wide[ZW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= eul2q_pkg::CORDIC_GAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_red_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < ITERS; i++) begin : g_iter
      eul2q_pkg::cordic_type x_in, y_in;
      logic                  pos;

      always_comb begin
         pos = !z_ff[i][ZW-1];
         if (pos) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            neg_ff[i+1] <= neg_ff[i];
         end
      end

      if (i < ITERS - 1) begin : g_z
         always_ff @(posedge clock) begin
            if (en) begin
               if (pos) begin
                  z_ff[i+1] <= z_ff[i] - eul2q_pkg::ATAN_TAB[i];
               end else begin
                  z_ff[i+1] <= z_ff[i] + eul2q_pkg::ATAN_TAB[i];
               end
            end
         end
      end
   end

   eul2q_pkg::cordic_type x_fix, y_fix, x_rnd, y_rnd;
   eul2q_pkg::q14_type    cos_in, sin_in;
   eul2q_pkg::q14_type    cos_ff, sin_ff;

   // Undo the range fold, round half up to Q1.14 and clamp to plus or minus one.
   always_comb begin
      x_fix = neg_ff[ITERS] ? -x_ff[ITERS] : x_ff[ITERS];
      y_fix = neg_ff[ITERS] ? -y_ff[ITERS] : y_ff[ITERS];
      x_rnd = (x_fix + eul2q_pkg::ROUND_Q16) >>> 16;
      y_rnd = (y_fix + eul2q_pkg::ROUND_Q16) >>> 16;
      if (x_rnd > eul2q_pkg::ONE_Q14) begin
         cos_in = 16'(eul2q_pkg::ONE_Q14);
      end else if (x_rnd < -eul2q_pkg::ONE_Q14) begin
         cos_in = 16'(-eul2q_pkg::ONE_Q14);
      end else begin
         cos_in = x_rnd[15:0];
      end
      if (y_rnd > eul2q_pkg::ONE_Q14) begin
         sin_in = 16'(eul2q_pkg::ONE_Q14);
      end else if (y_rnd < -eul2q_pkg::ONE_Q14) begin
         sin_in = 16'(-eul2q_pkg::ONE_Q14);
      end else begin
         sin_in = y_rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q14 = cos_ff;
   assign sin_q14 = sin_ff;

endmodule

/* sv/eul2q_merge.sv */
// Merge stage: forms w, x, y and z from triple products of the lanes' sines and cosines.
// Depends on eul2q_pkg. Its registered stages advance only while en is high, the last one
// being the result register.
module eul2q_merge (
   input  logic               clock,
   input  logic               en,
   input  eul2q_pkg::q14_type sr,
   input  eul2q_pkg::q14_type cr,
   input  eul2q_pkg::q14_type sp,
   input  eul2q_pkg::q14_type cp,
   input  eul2q_pkg::q14_type sy,
   input  eul2q_pkg::q14_type cy,
   output eul2q_pkg::q14_type quat_w,
   output eul2q_pkg::q14_type quat_x,
   output eul2q_pkg::q14_type quat_y,
   output eul2q_pkg::q14_type quat_z
);

   localparam int PW = 32;
   localparam int TW = 48;
   localparam int SW = 49;
   localparam logic signed [SW-1:0] ROUND_Q28 = 49'sd134217728;

   // First stage: roll and pitch pair products.
   logic signed [PW-1:0] p_cc_ff, p_ss_ff, p_sc_ff, p_cs_ff;
   eul2q_pkg::q14_type   sy1_ff, cy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_cc_ff <= PW'(cr) * PW'(cp);
         p_ss_ff <= PW'(sr) * PW'(sp);
         p_sc_ff <= PW'(sr) * PW'(cp);
         p_cs_ff <= PW'(cr) * PW'(sp);
         sy1_ff  <= sy;
         cy1_ff  <= cy;
      end
   end

   // Second stage: the eight triple products, exact in Q.42.
   logic signed [TW-1:0] t_ccc_ff, t_sss_ff, t_scc_ff, t_css_ff;
   logic signed [TW-1:0] t_csc_ff, t_scs_ff, t_ccs_ff, t_ssc_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_ccc_ff <= TW'(p_cc_ff) * TW'(cy1_ff);
         t_sss_ff <= TW'(p_ss_ff) * TW'(sy1_ff);
         t_scc_ff <= TW'(p_sc_ff) * TW'(cy1_ff);
         t_css_ff <= TW'(p_cs_ff) * TW'(sy1_ff);
         t_csc_ff <= TW'(p_cs_ff) * TW'(cy1_ff);
         t_scs_ff <= TW'(p_sc_ff) * TW'(sy1_ff);
         t_ccs_ff <= TW'(p_cc_ff) * TW'(sy1_ff);
         t_ssc_ff <= TW'(p_ss_ff) * TW'(cy1_ff);
      end
   end

   // Third stage: exact sums and differences.
   logic signed [SW-1:0] s_w_ff, s_x_ff, s_y_ff, s_z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s_w_ff <= SW'(t_ccc_ff) + SW'(t_sss_ff);
         s_x_ff <= SW'(t_scc_ff) - SW'(t_css_ff);
         s_y_ff <= SW'(t_csc_ff) + SW'(t_scs_ff);
         s_z_ff <= SW'(t_ccs_ff) - SW'(t_ssc_ff);
      end
   end

   function automatic eul2q_pkg::q14_type finish(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] r;
      r = (s + ROUND_Q28) >>> 28;
      if (r > eul2q_pkg::ONE_Q14) begin
         return 16'(eul2q_pkg::ONE_Q14);
      end else if (r < -eul2q_pkg::ONE_Q14) begin
         return 16'(-eul2q_pkg::ONE_Q14);
      end
      return r[15:0];
   endfunction

   // Fourth stage: round to Q1.14, saturate, hold as the result register.
   eul2q_pkg::q14_type q_w_ff, q_x_ff, q_y_ff, q_z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q_w_ff <= finish(s_w_ff);
         q_x_ff <= finish(s_x_ff);
         q_y_ff <= finish(s_y_ff);
         q_z_ff <= finish(s_z_ff);
      end
   end

   assign quat_w = q_w_ff;
   assign quat_x = q_x_ff;
   assign quat_y = q_y_ff;
   assign quat_z = q_z_ff;

endmodule

/* sv/euler_to_quaternion.sv */
// Euler angles (Z-Y-X order) to unit quaternion, three CORDIC lanes and a merge stage.
// Structure: each lane is a 24-step CORDIC pipeline (26 stages), followed by the 4-stage
// triple product merge.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active high; clears the valid pipeline only, data is not reset.
// Depends on eul2q_pkg, eul2q_cordic_lane and eul2q_merge.
module euler_to_quaternion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // quat_w [15:0], quat_x [31:16], quat_y [47:32],
                                    // quat_z [63:48]
);

   localparam int LAT = eul2q_pkg::PIPE_LAT;

   logic [LAT-1:0] valid_ff, valid_in;
   logic           advance;

   // The pipeline moves whenever the result register is empty or being drained.
   assign advance    = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   eul2q_pkg::q14_type sr, cr, sp, cp, sy, cy;
   eul2q_pkg::q14_type quat_w, quat_x, quat_y, quat_z;

   eul2q_cordic_lane u_lane_roll (
      .clock   (clock),
      .en      (advance),
      .angle   (req_tdata[15:0]),
      .sin_q14 (sr),
      .cos_q14 (cr)
   );

   eul2q_cordic_lane u_lane_pitch (
      .clock   (clock),
      .en      (advance),
      .angle   (req_tdata[31:16]),
      .sin_q14 (sp),
      .cos_q14 (cp)
   );

   eul2q_cordic_lane u_lane_yaw (
      .clock   (clock),
      .en      (advance),
      .angle   (req_tdata[47:32]),
      .sin_q14 (sy),
      .cos_q14 (cy)
   );

   eul2q_merge u_merge (
      .clock  (clock),
      .en     (advance),
      .sr     (sr),
      .cr     (cr),
      .sp     (sp),
      .cp     (cp),
      .sy     (sy),
      .cy     (cy),
      .quat_w (quat_w),
      .quat_x (quat_x),
      .quat_y (quat_y),
      .quat_z (quat_z)
   );

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {quat_z, quat_y, quat_x, quat_w};

endmodule

/* sv/eul2q_checker.sv */
// Port-level checks of the Euler angle to quaternion block, bound to its top level.
// Depends on euler_to_quaternion_defines.svh.
`include "euler_to_quaternion_defines.svh"

module eul2q_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic rsp_stall;
   logic rsp_in_unit;

   function automatic logic in_unit(input logic [15:0] v);
      return ($signed(v) <= 16'sd16384) && ($signed(v) >= -16'sd16384);
   endfunction

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_in_unit = in_unit(rsp_tdata[15:0]) && in_unit(rsp_tdata[31:16]) &&
                        in_unit(rsp_tdata[47:32]) && in_unit(rsp_tdata[63:48]);

   // A stalled result keeps its beat.
   `E2Q_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result beat moved")

   // With an empty result register the block always takes input.
   `E2Q_ASSERT_ALWAYS(a_ready_when_empty, rsp_tvalid || req_tready, "input stalled while empty")

   // A draining consumer never stalls the input side.
   `E2Q_ASSERT_ALWAYS(a_ready_when_drained, !rsp_tready || req_tready, "input stalled on drain")

   // Every component stays within plus or minus one in Q1.14.
   `E2Q_ASSERT_ALWAYS(a_unit_range, !rsp_tvalid || rsp_in_unit, "component out of range")

endmodule

bind euler_to_quaternion eul2q_checker u_eul2q_checker (.*);

/* tb/sv/euler_to_quaternion_tb.sv */
// Self-checking testbench for euler_to_quaternion: directed angle table, then random beats.
// Expected quaternions come from a bit-exact CORDIC predictor; depends on eul2q_pkg and the RTL.
`timescale 1ns / 100ps

module euler_to_quaternion_tb;

   typedef struct packed {
      eul2q_pkg::q14_type z;
      eul2q_pkg::q14_type y;
      eul2q_pkg::q14_type x;
      eul2q_pkg::q14_type w;
   } quat_type;

   // Directed row: a typed quaternion is used only when known is set.
   typedef struct packed {
      logic                 known;
      eul2q_pkg::q14_type   w, x, y, z;
      eul2q_pkg::angle_type roll, pitch, yaw;
   } angle_row_type;

   localparam int STEPS = 24;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam longint PI_Q30_L = 64'sd3373259426;
   localparam longint ONE_Q14_L = 64'sd16384;
   localparam longint ARCTAN_Q30 [STEPS] = '{
      843314856, 497837829, 263043836, 133525158,
      67021686, 33543515, 16775850, 8388437,
      4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767,
      16383, 8191, 4095, 2047,
      1023, 511, 255, 127
   };

   localparam int RANDOM_BEATS = 1530;
   localparam int LONG_HOLD = 300;
   localparam int HOLD_AFTER_BEATS = 400;
   localparam int IDLE_LIMIT = 4000;

   localparam int DIR_ROWS = 19;
   localparam angle_row_type ANGLE_TABLE [DIR_ROWS] = '{
      // known, w, x, y, z, roll, pitch, yaw
      {1'b1, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h0000, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h7FFF, 16'h7FFF, 16'h7FFF},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h8000, 16'h8000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7FFF, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0001, 16'h0001, 16'h0001},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      // Half angle just below and just above pi/2, both signs.
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h3243, 16'h0000, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h3244, 16'h0000, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hCDBD, 16'h0000, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hCDBC, 16'h0000, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h3244, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h0000, 16'hCDBC},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h1922, 16'h1922, 16'h1922},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hE6DE, 16'h1922, 16'hE6DE},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h6488, 16'h0000, 16'h0000},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h9B78, 16'h6488},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h5555, 16'hAAAA, 16'h0F0F},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hAAAA, 16'h5555, 16'hF0F0},
      {1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0C90, 16'hF370, 16'h3244}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;       // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]

   // Travels with each offered beat: a typed quaternion overrides the predictor.
   logic     req_known = 1'b0;
   quat_type req_known_quat = '0;

   quat_type pending_quats [$];
   int       mismatches = 0;
   int       beats_in = 0;
   int       idle_cycles = 0;
   bit       held_off = 1'b0;

   euler_to_quaternion DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clamp_unit_q14(longint v);
      if (v > ONE_Q14_L) return ONE_Q14_L;
      if (v < -ONE_Q14_L) return -ONE_Q14_L;
      return v;
   endfunction

   // Sine and cosine of half the Q4.12 angle, both rounded to Q1.14.
   function automatic void half_angle_sincos(input eul2q_pkg::angle_type ang,
                                             output longint sin14, output longint cos14);
      longint phase, cx, cy, nx;
      bit     flip;
      int     i;
      phase = longint'(ang) * 64'sd131072;
      flip = 1'b0;
      cx = GAIN_Q30;
      cy = 0;
      if (phase > HALF_PI_Q30_L) begin
         phase -= PI_Q30_L;
         flip = 1'b1;
      end else if (phase < -HALF_PI_Q30_L) begin
         phase += PI_Q30_L;
         flip = 1'b1;
      end
      for (i = 0; i < STEPS; i++) begin
         if (phase >= 0) begin
            nx = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            phase -= ARCTAN_Q30[i];
         end else begin
            nx = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            phase += ARCTAN_Q30[i];
         end
         cx = nx;
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      cos14 = clamp_unit_q14((cx + 64'sd32768) >>> 16);
      sin14 = clamp_unit_q14((cy + 64'sd32768) >>> 16);
   endfunction

   function automatic eul2q_pkg::q14_type round_q42(longint s);
      return eul2q_pkg::q14_type'(clamp_unit_q14((s + 64'sd134217728) >>> 28));
   endfunction

   function automatic quat_type predict_quaternion(eul2q_pkg::angle_type roll,
                                                   eul2q_pkg::angle_type pitch,
                                                   eul2q_pkg::angle_type yaw);
      longint   sr, cr, sp, cp, sy, cy;
      quat_type q;
      half_angle_sincos(roll, sr, cr);
      half_angle_sincos(pitch, sp, cp);
      half_angle_sincos(yaw, sy, cy);
      q.w = round_q42(cr * cp * cy + sr * sp * sy);
      q.x = round_q42(sr * cp * cy - cr * sp * sy);
      q.y = round_q42(cr * sp * cy + sr * cp * sy);
      q.z = round_q42(cr * cp * sy - sr * sp * cy);
      return q;
   endfunction

   // Mostly full-range values, with extra weight on small angles, the
   // range-reduction boundary and the field extremes.
   function automatic eul2q_pkg::angle_type pick_angle();
      int sel, base;
      sel = $urandom_range(0, 9);
      if (sel <= 5) return eul2q_pkg::angle_type'($urandom_range(0, 65535));
      if (sel <= 7) return eul2q_pkg::angle_type'(int'($urandom_range(0, 1024)) - 512);
      if (sel == 8) begin
         base = ($urandom_range(0, 1) != 0) ? 12868 : -12868;
         return eul2q_pkg::angle_type'(base + int'($urandom_range(0, 32)) - 16);
      end
      case ($urandom_range(0, 4))
         0: return eul2q_pkg::angle_type'(-32768);
         1: return eul2q_pkg::angle_type'(32767);
         2: return eul2q_pkg::angle_type'(-1);
         3: return eul2q_pkg::angle_type'(1);
         default: return eul2q_pkg::angle_type'(0);
      endcase
   endfunction

   // Idle length: most gaps are short, a few are long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic offer_angles(eul2q_pkg::angle_type roll, eul2q_pkg::angle_type pitch,
                               eul2q_pkg::angle_type yaw, logic known,
                               quat_type known_quat, bit no_gap);
      int gap;
      req_tdata <= {yaw, pitch, roll};
      req_known <= known;
      req_known_quat <= known_quat;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = no_gap ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Both handshakes are observed here, so expectations and results are
   // ordered the same way regardless of process scheduling.
   always @(posedge clock) begin
      quat_type got, want, next_quat;
      int       k;
      if (!reset) begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            beats_in++;
            if (req_known)
               next_quat = req_known_quat;
            else
               next_quat = predict_quaternion(req_tdata[15:0], req_tdata[31:16],
                                              req_tdata[47:32]);
            pending_quats.insert(pending_quats.size(), next_quat);
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            got = rsp_tdata;
            if (pending_quats.size() == 0) begin
               mismatches++;
               $display("%0t: quaternion beat with none expected, got %h", $time, rsp_tdata);
            end else begin
               want = pending_quats.pop_front();
               for (k = 0; k < 4; k++) begin
                  if (got[k*16 +: 16] !== want[k*16 +: 16]) begin
                     mismatches++;
                     $display("%0t: quat component %0d expected %0d, actual %0d", $time, k,
                              $signed(want[k*16 +: 16]), $signed(got[k*16 +: 16]));
                  end
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("euler_to_quaternion_tb: done, errors");
      $finish;
   end

   // Result side: random stalls, stretches of steady ready, and one long hold-off
   // that lets the pipeline fill and push back on the angle side.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && beats_in >= HOLD_AFTER_BEATS) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIR_ROWS; n++)
         offer_angles(ANGLE_TABLE[n].roll, ANGLE_TABLE[n].pitch, ANGLE_TABLE[n].yaw,
                      ANGLE_TABLE[n].known,
                      {ANGLE_TABLE[n].z, ANGLE_TABLE[n].y, ANGLE_TABLE[n].x, ANGLE_TABLE[n].w},
                      1'b0);

      // Every fourth block of a hundred beats is offered back to back.
      for (n = 0; n < RANDOM_BEATS; n++)
         offer_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, '0,
                      ((n / 100) % 4) == 3);
      req_tvalid <= 1'b0;

      while (pending_quats.size() != 0) @(posedge clock);
      repeat (eul2q_pkg::PIPE_LAT + 8) @(posedge clock);
      if (mismatches == 0)
         $display("euler_to_quaternion_tb: done, clean");
      else
         $display("euler_to_quaternion_tb: done, errors");
      $finish;
   end

endmodule
